>>> hdl/gbe_pkg.sv
`default_nettype none

package gbe_pkg;

	// Fixed field widths of the command and result channels.
	localparam int CMD_W  = 3;
	localparam int BYTE_W = 8;
	localparam int CNT_W  = 11;
	localparam int OUT_W  = 11;

	// Command codes.
	typedef enum logic [CMD_W-1:0] {
		CMD_CLEAR    = 3'd0,
		CMD_INSERT   = 3'd1,
		CMD_DELETE   = 3'd2,
		CMD_FORWARD  = 3'd3,
		CMD_BACKWARD = 3'd4,
		CMD_PEEK     = 3'd5
	} cmd_t;

endpackage

`default_nettype wire

>>> hdl/gap_buffer_engine_top.sv
`default_nettype none

// Gap buffer engine: a byte store of CAPACITY entries with a movable gap.
// A command transfer happens at a rising edge where start is high and busy
// is low; cmd, data_byte and count are sampled there. busy then stays high
// until the result has been shown. The result appears on the result ports
// for exactly one cycle, marked by done; the receiver cannot stall it, so
// it must take the result in that cycle.
// Sequence: clear, insert, delete, refused commands and zero-length moves
// go from the check step straight to the result; peek adds a step for the
// registered store read; a gap move copies in the copy state and then
// drains the last write before the result. A new command is taken only
// once the engine is idle again after done, so commands never overlap.
// The move rate is set by the single store port pair: one byte is read and
// one written per cycle.
// Reset sets the gap to cover the whole store (cursor at zero, empty text);
// the store contents are not cleared, and no result is shown after reset.
module gap_buffer_engine_top #(
	parameter int CAPACITY = 1024
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	input  logic [gbe_pkg::CMD_W-1:0]   cmd,
	input  logic [gbe_pkg::BYTE_W-1:0]  data_byte,
	input  logic [gbe_pkg::CNT_W-1:0]   count,
	output logic                        done,
	output logic                        ok,
	output logic [gbe_pkg::BYTE_W-1:0]  peek_byte,
	output logic [gbe_pkg::OUT_W-1:0]   cursor_pos,
	output logic [gbe_pkg::OUT_W-1:0]   text_len,
	output logic [gbe_pkg::OUT_W-1:0]   gap_size,
	output logic                        at_left,
	output logic                        at_right
);
	import gbe_pkg::*;

	localparam int PW = $clog2(CAPACITY + 1);
	localparam int AW = $clog2(CAPACITY);
	localparam int SW = ((PW > CNT_W) ? PW : CNT_W) + 1;
	localparam logic [PW-1:0] CAP_P = PW'(CAPACITY);
	localparam logic [SW-1:0] CAP_X = SW'(CAPACITY);

	typedef enum logic [5:0] {
		ST_IDLE  = 6'b000001,
		ST_CHECK = 6'b000010,
		ST_COPY  = 6'b000100,
		ST_DRAIN = 6'b001000,
		ST_PEEK  = 6'b010000,
		ST_DONE  = 6'b100000
	} state_t;

	state_t            state_q;
	cmd_t              cmd_q;
	logic [BYTE_W-1:0] data_q;
	logic [CNT_W-1:0]  count_q;
	logic [CNT_W-1:0]  rem_q;
	logic [PW-1:0]     gap_first_q;
	logic [PW-1:0]     gap_last_q;
	logic [AW-1:0]     src_q;
	logic [AW-1:0]     dst_q;
	logic              fwd_q;
	logic              ok_q;
	logic [BYTE_W-1:0] peek_q;
	logic              wr_pend_s1;
	logic [AW-1:0]     wr_addr_s1;

	logic [SW-1:0]     first_x;
	logic [SW-1:0]     last_x;
	logic [SW-1:0]     cnt_x;
	logic [SW-1:0]     end_x;
	logic [SW-1:0]     gap_x;
	logic [SW-1:0]     len_x;
	logic [PW-1:0]     first_dec;
	logic [PW-1:0]     last_dec;
	logic              end_fits;
	logic              back_fits;
	logic              gap_open;
	logic              left_w;
	logic              right_w;

	logic              mem_we;
	logic [AW-1:0]     mem_waddr;
	logic [BYTE_W-1:0] mem_wdata;
	logic [AW-1:0]     mem_raddr;
	logic [BYTE_W-1:0] mem_rdata;

	// Bound checks on the pointers against the latched count, and the derived sizes and end flags.
	always_comb begin
		first_x   = SW'(gap_first_q);
		last_x    = SW'(gap_last_q);
		cnt_x     = SW'(count_q);
		end_x     = last_x + cnt_x;
		gap_x     = last_x - first_x;
		len_x     = CAP_X - gap_x;
		first_dec = gap_first_q - PW'(1);
		last_dec  = gap_last_q - PW'(1);
		end_fits  = (end_x <= CAP_X);
		back_fits = (cnt_x <= first_x);
		gap_open  = (gap_last_q > gap_first_q);
		left_w    = (gap_first_q == '0);
		right_w   = (gap_last_q == CAP_P);
	end

	// Store port steering: a pending copy write, or the insert write; the read address is the gap end in the check step.
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = wr_addr_s1;
		mem_wdata = mem_rdata;
		mem_raddr = src_q;
		if (wr_pend_s1) begin
			mem_we = 1'b1;
		end else if (state_q == ST_CHECK && cmd_q == CMD_INSERT && gap_open) begin
			mem_we    = 1'b1;
			mem_waddr = gap_first_q[AW-1:0];
			mem_wdata = data_q;
		end
		if (state_q == ST_CHECK) begin
			mem_raddr = gap_last_q[AW-1:0];
		end
	end

	gbe_store #(
		.DEPTH(CAPACITY)
	) u_store (
		.clk  (clk),
		.we   (mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.raddr(mem_raddr),
		.rdata(mem_rdata)
	);

	// Sequencer and gap pointers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			gap_first_q <= '0;
			gap_last_q  <= CAP_P;
			wr_pend_s1  <= 1'b0;
		end else begin
			wr_pend_s1 <= (state_q == ST_COPY);
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						state_q <= ST_CHECK;
					end
				end
				ST_CHECK: begin
					state_q <= ST_DONE;
					case (cmd_q)
						CMD_CLEAR: begin
							gap_first_q <= '0;
							gap_last_q  <= CAP_P;
						end
						CMD_INSERT: begin
							if (gap_open) begin
								gap_first_q <= gap_first_q + PW'(1);
							end
						end
						CMD_DELETE: begin
							if (end_fits) begin
								gap_last_q <= end_x[PW-1:0];
							end
						end
						CMD_FORWARD: begin
							if (!right_w && end_fits && count_q != '0) begin
								state_q <= ST_COPY;
							end
						end
						CMD_BACKWARD: begin
							if (!left_w && back_fits && count_q != '0) begin
								state_q <= ST_COPY;
							end
						end
						CMD_PEEK: begin
							if (!right_w) begin
								state_q <= ST_PEEK;
							end
						end
						default: begin
						end
					endcase
				end
				ST_COPY: begin
					if (rem_q == CNT_W'(1)) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					// The last byte is written this cycle; the gap moves now.
					state_q <= ST_DONE;
					if (fwd_q) begin
						gap_first_q <= PW'(first_x + cnt_x);
						gap_last_q  <= end_x[PW-1:0];
					end else begin
						gap_first_q <= PW'(first_x - cnt_x);
						gap_last_q  <= PW'(last_x - cnt_x);
					end
				end
				ST_PEEK: begin
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Command latch, copy walkers and result payload.
	always_ff @(posedge clk) begin
		wr_addr_s1 <= dst_q;
		unique case (state_q) inside
			ST_IDLE: begin
				if (start) begin
					cmd_q   <= cmd_t'(cmd);
					data_q  <= data_byte;
					count_q <= count;
				end
			end
			ST_CHECK: begin
				ok_q   <= 1'b0;
				peek_q <= '0;
				rem_q  <= count_q;
				case (cmd_q)
					CMD_CLEAR: begin
						ok_q <= 1'b1;
					end
					CMD_INSERT: begin
						ok_q <= gap_open;
					end
					CMD_DELETE: begin
						ok_q <= end_fits;
					end
					CMD_FORWARD: begin
						ok_q  <= !right_w && end_fits;
						fwd_q <= 1'b1;
						src_q <= gap_last_q[AW-1:0];
						dst_q <= gap_first_q[AW-1:0];
					end
					CMD_BACKWARD: begin
						ok_q  <= !left_w && back_fits;
						fwd_q <= 1'b0;
						src_q <= first_dec[AW-1:0];
						dst_q <= last_dec[AW-1:0];
					end
					CMD_PEEK: begin
						ok_q <= !right_w;
					end
					default: begin
					end
				endcase
			end
			ST_COPY: begin
				// Forward copies ascend, backward copies descend.
				rem_q <= rem_q - CNT_W'(1);
				if (fwd_q) begin
					src_q <= src_q + AW'(1);
					dst_q <= dst_q + AW'(1);
				end else begin
					src_q <= src_q - AW'(1);
					dst_q <= dst_q - AW'(1);
				end
			end
			ST_PEEK: begin
				peek_q <= mem_rdata;
			end
			ST_DRAIN, ST_DONE: begin
			end
			default: begin
			end
		endcase
	end

	// Result ports.
	assign busy       = (state_q != ST_IDLE);
	assign done       = (state_q == ST_DONE);
	assign ok         = ok_q;
	assign peek_byte  = peek_q;
	assign cursor_pos = first_x[OUT_W-1:0];
	assign gap_size   = gap_x[OUT_W-1:0];
	assign text_len   = len_x[OUT_W-1:0];
	assign at_left    = left_w;
	assign at_right   = right_w;

	// The gap always lies inside the store.
	a_ptr_order: assert property (@(posedge clk) disable iff (!arst_n)
		(gap_first_q <= gap_last_q) && (gap_last_q <= CAP_P))
		else $error("gap pointers out of order");

	// An accepted command goes straight to the check step.
	a_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> (state_q == ST_CHECK))
		else $error("accepted command not checked");

	// A result is shown for one cycle and the engine is then free.
	a_done_once: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> (!done && !busy))
		else $error("result strobe not single");

	// A refused command leaves the gap where it was.
	a_refused: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !ok) |-> ($stable(gap_first_q) && $stable(gap_last_q)))
		else $error("refused command moved the gap");

	// Every copy read is followed by its write.
	a_copy_write: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_COPY) |=> wr_pend_s1)
		else $error("copy write lost");

endmodule

`default_nettype wire

>>> hdl/gbe_store.sv
`default_nettype none

module gbe_store #(
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [gbe_pkg::BYTE_W-1:0] wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [gbe_pkg::BYTE_W-1:0] rdata
);
	import gbe_pkg::*;

	logic [BYTE_W-1:0] mem [DEPTH];

	// One write port and one registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

>>> bench/tb_gap_buffer_engine_top.sv
module tb_gap_buffer_engine_top;
	timeunit 1ns;
	timeprecision 1ps;

	import gbe_pkg::*;

	localparam int CAP = 1024;
	localparam int WATCHDOG = 6000;
	localparam int FILL_N = 200;
	localparam int N_RANDOM = 610;

	// Command codes the block does not define; both must be refused.
	localparam logic [CMD_W-1:0] CMD_SPARE_LO = 3'd6;
	localparam logic [CMD_W-1:0] CMD_SPARE_HI = 3'd7;

	// One result transfer, in port order.
	typedef struct packed {
		logic              ok;
		logic [BYTE_W-1:0] peek;
		logic [OUT_W-1:0]  cursor;
		logic [OUT_W-1:0]  length;
		logic [OUT_W-1:0]  gap;
		logic              at_left;
		logic              at_right;
	} gap_result_t;

	// One directed command; when typed is set, res is the known answer.
	typedef struct packed {
		logic [CMD_W-1:0]  op;
		logic [BYTE_W-1:0] din;
		logic [CNT_W-1:0]  n;
		logic              typed;
		gap_result_t       res;
	} gap_row_t;

	localparam int N_DIR = 25;
	localparam gap_row_t DIR_ROWS [N_DIR] = '{
		// Fresh after reset: everything at the right end and the left end at once.
		'{CMD_PEEK,     8'h00, 11'd0,    1'b1, '{1'b0, 8'h00, 11'd0, 11'd0, 11'd1024, 1'b1, 1'b1}},
		'{CMD_FORWARD,  8'h00, 11'd0,    1'b1, '{1'b0, 8'h00, 11'd0, 11'd0, 11'd1024, 1'b1, 1'b1}},
		'{CMD_BACKWARD, 8'h00, 11'd0,    1'b1, '{1'b0, 8'h00, 11'd0, 11'd0, 11'd1024, 1'b1, 1'b1}},
		'{CMD_DELETE,   8'h00, 11'd0,    1'b1, '{1'b1, 8'h00, 11'd0, 11'd0, 11'd1024, 1'b1, 1'b1}},
		'{CMD_DELETE,   8'h00, 11'd1,    1'b1, '{1'b0, 8'h00, 11'd0, 11'd0, 11'd1024, 1'b1, 1'b1}},
		'{CMD_DELETE,   8'hFF, 11'd2047, 1'b1, '{1'b0, 8'h00, 11'd0, 11'd0, 11'd1024, 1'b1, 1'b1}},
		'{CMD_SPARE_LO, 8'h00, 11'd0,    1'b1, '{1'b0, 8'h00, 11'd0, 11'd0, 11'd1024, 1'b1, 1'b1}},
		'{CMD_SPARE_HI, 8'hFF, 11'd2047, 1'b1, '{1'b0, 8'h00, 11'd0, 11'd0, 11'd1024, 1'b1, 1'b1}},
		'{CMD_INSERT,   8'hFF, 11'd2047, 1'b1, '{1'b1, 8'h00, 11'd1, 11'd1, 11'd1023, 1'b0, 1'b1}},
		'{CMD_INSERT,   8'h00, 11'd0,    1'b1, '{1'b1, 8'h00, 11'd2, 11'd2, 11'd1022, 1'b0, 1'b1}},
		// Small text: walk the gap over it, both inside and past the bounds.
		'{CMD_INSERT,   8'hA5, 11'd0,    1'b0, '0},
		'{CMD_BACKWARD, 8'h00, 11'd0,    1'b0, '0},
		'{CMD_BACKWARD, 8'h00, 11'd3,    1'b0, '0},
		'{CMD_PEEK,     8'h00, 11'd0,    1'b0, '0},
		'{CMD_FORWARD,  8'h00, 11'd1,    1'b0, '0},
		'{CMD_BACKWARD, 8'h00, 11'd5,    1'b0, '0},
		'{CMD_FORWARD,  8'h00, 11'd3,    1'b0, '0},
		'{CMD_FORWARD,  8'h00, 11'd2,    1'b0, '0},
		'{CMD_BACKWARD, 8'h00, 11'd2,    1'b0, '0},
		'{CMD_DELETE,   8'h00, 11'd1,    1'b0, '0},
		'{CMD_PEEK,     8'h00, 11'd0,    1'b0, '0},
		'{CMD_DELETE,   8'h00, 11'd2047, 1'b0, '0},
		// Clear drops the text; the next peek has nothing after the gap.
		'{CMD_CLEAR,    8'h00, 11'd0,    1'b1, '{1'b1, 8'h00, 11'd0, 11'd0, 11'd1024, 1'b1, 1'b1}},
		'{CMD_INSERT,   8'h5A, 11'd0,    1'b1, '{1'b1, 8'h00, 11'd1, 11'd1, 11'd1023, 1'b0, 1'b1}},
		'{CMD_PEEK,     8'h00, 11'd0,    1'b1, '{1'b0, 8'h00, 11'd1, 11'd1, 11'd1023, 1'b0, 1'b1}}
	};

	logic                clk;
	logic                arst_n = 1'b0;
	logic                start = 1'b0;
	logic [CMD_W-1:0]    cmd = '0;
	logic [BYTE_W-1:0]   data_byte = '0;
	logic [CNT_W-1:0]    count = '0;
	logic                busy;
	logic                done;
	logic                ok;
	logic [BYTE_W-1:0]   peek_byte;
	logic [OUT_W-1:0]    cursor_pos;
	logic [OUT_W-1:0]    text_len;
	logic [OUT_W-1:0]    gap_size;
	logic                at_left;
	logic                at_right;

	gap_buffer_engine_top #(.CAPACITY(CAP)) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.cmd(cmd),
		.data_byte(data_byte),
		.count(count),
		.done(done),
		.ok(ok),
		.peek_byte(peek_byte),
		.cursor_pos(cursor_pos),
		.text_len(text_len),
		.gap_size(gap_size),
		.at_left(at_left),
		.at_right(at_right)
	);

	// Shadow copy of the buffer, updated as each command transfer happens.
	bit [BYTE_W-1:0] text_mem [CAP];
	int              gap_first = 0;
	int              gap_last = CAP;

	gap_result_t     pending_q [$];
	int              n_bad = 0;
	int              n_sent = 0;
	int              burst_left = 1;
	int              idle_cycles = 0;

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Apply one command to the shadow buffer and return the answer it should give.
	function automatic gap_result_t gap_apply(logic [CMD_W-1:0] op, logic [BYTE_W-1:0] din,
			logic [CNT_W-1:0] n);
		gap_result_t r;
		int cnt;
		int span;
		r = '0;
		cnt = int'(n);
		case (op)
			CMD_CLEAR: begin
				gap_first = 0;
				gap_last = CAP;
				r.ok = 1'b1;
			end
			CMD_INSERT: begin
				if (gap_last > gap_first) begin
					text_mem[gap_first] = din;
					gap_first++;
					r.ok = 1'b1;
				end
			end
			CMD_DELETE: begin
				if (gap_last + cnt <= CAP) begin
					gap_last += cnt;
					r.ok = 1'b1;
				end
			end
			CMD_FORWARD: begin
				if (gap_last != CAP && gap_last + cnt <= CAP) begin
					for (int k = 0; k < cnt; k++)
						text_mem[gap_first + k] = text_mem[gap_last + k];
					gap_first += cnt;
					gap_last += cnt;
					r.ok = 1'b1;
				end
			end
			CMD_BACKWARD: begin
				if (gap_first != 0 && cnt <= gap_first) begin
					// Copy from the top down so the source is never overwritten early.
					for (int k = cnt - 1; k >= 0; k--)
						text_mem[gap_last - cnt + k] = text_mem[gap_first - cnt + k];
					gap_first -= cnt;
					gap_last -= cnt;
					r.ok = 1'b1;
				end
			end
			CMD_PEEK: begin
				if (gap_last < CAP) begin
					r.peek = text_mem[gap_last];
					r.ok = 1'b1;
				end
			end
			default: begin
			end
		endcase
		span = gap_last - gap_first;
		r.cursor = OUT_W'(gap_first);
		r.gap = OUT_W'(span);
		r.length = OUT_W'(CAP - span);
		r.at_left = (gap_first == 0);
		r.at_right = (gap_last == CAP);
		return r;
	endfunction

	// Mostly short spans, now and then anything up to the limit.
	function automatic logic [CNT_W-1:0] pick_span(int lim);
		int hi;
		hi = (lim < 16) ? lim : 16;
		if ($urandom_range(0, 6) == 0)
			return CNT_W'($urandom_range(0, lim));
		return CNT_W'($urandom_range(0, hi));
	endfunction

	// Drive one command until its transfer, record the answer, then maybe idle.
	task automatic issue(input logic [CMD_W-1:0] op, input logic [BYTE_W-1:0] din,
			input logic [CNT_W-1:0] n, input logic typed, input gap_result_t known);
		gap_result_t want;
		int idle;
		start <= 1'b1;
		cmd <= op;
		data_byte <= din;
		count <= n;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		want = gap_apply(op, din, n);
		if (typed)
			want = known;
		pending_q.push_back(want);
		n_sent++;
		burst_left--;
		if (burst_left <= 0) begin
			burst_left = $urandom_range(1, 40);
			idle = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
			if (idle > 0) begin
				start <= 1'b0;
				repeat (idle)
					@(posedge clk);
			end
		end
	endtask

	// Result checker: each strobed result against the oldest expectation.
	always @(posedge clk) begin
		gap_result_t got;
		gap_result_t want;
		if (arst_n && done) begin
			got = '{ok, peek_byte, cursor_pos, text_len, gap_size, at_left, at_right};
			if (pending_q.size() == 0) begin
				n_bad++;
				if (n_bad <= 10)
					$display("%0t: result with no command pending", $realtime);
			end else begin
				want = pending_q.pop_front();
				if (got.ok !== want.ok || got.peek !== want.peek
						|| got.cursor !== want.cursor || got.length !== want.length
						|| got.gap !== want.gap || got.at_left !== want.at_left
						|| got.at_right !== want.at_right) begin
					n_bad++;
					if (n_bad <= 10)
						$display("%0t: mismatch ok/peek/cursor/len/gap/left/right",
							$realtime,
							" exp %0d/%0h/%0d/%0d/%0d/%0d/%0d", want.ok, want.peek,
							want.cursor, want.length, want.gap, want.at_left,
							want.at_right,
							" got %0d/%0h/%0d/%0d/%0d/%0d/%0d", got.ok, got.peek,
							got.cursor, got.length, got.gap, got.at_left, got.at_right);
				end
			end
		end
	end

	// Watchdog: too long without a command or result transfer ends the run.
	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= WATCHDOG) begin
			$display("== FAIL ==");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	// Stimulus: directed table, one fill-and-sweep, then random edit sessions.
	initial begin
		int base;
		int reps;
		logic [CMD_W-1:0] op;
		repeat (9)
			@(posedge clk);
		arst_n <= 1'b1;
		repeat (2)
			@(posedge clk);

		for (int i = 0; i < N_DIR; i++)
			issue(DIR_ROWS[i].op, DIR_ROWS[i].din, DIR_ROWS[i].n, DIR_ROWS[i].typed,
				DIR_ROWS[i].res);

		// Type a block of text, then sweep the gap end to end and past each bound.
		repeat (FILL_N)
			issue(CMD_INSERT, 8'($urandom), CNT_W'($urandom_range(0, 2047)), 1'b0, '0);
		issue(CMD_DELETE, 8'h00, 11'd0, 1'b0, '0);
		issue(CMD_BACKWARD, 8'h00, CNT_W'(gap_first), 1'b0, '0);
		issue(CMD_PEEK, 8'h00, 11'd0, 1'b0, '0);
		issue(CMD_BACKWARD, 8'h00, 11'd1, 1'b0, '0);
		issue(CMD_FORWARD, 8'h00, CNT_W'(CAP - gap_last + 1), 1'b0, '0);
		issue(CMD_FORWARD, 8'h00, CNT_W'(CAP - gap_last), 1'b0, '0);
		issue(CMD_PEEK, 8'h00, 11'd0, 1'b0, '0);
		issue(CMD_BACKWARD, 8'h00, CNT_W'(gap_first / 2), 1'b0, '0);
		issue(CMD_PEEK, 8'h00, 11'd0, 1'b0, '0);
		issue(CMD_DELETE, 8'h00, CNT_W'(CAP - gap_last + 1), 1'b0, '0);
		issue(CMD_DELETE, 8'h00, CNT_W'(CAP - gap_last), 1'b0, '0);

		base = n_sent;
		while (n_sent - base < N_RANDOM) begin
			case ($urandom_range(0, 9)) inside
				[0:2]: begin
					// Typing: a run of inserts, with the odd peek.
					reps = $urandom_range(1, 24);
					repeat (reps) begin
						if ($urandom_range(0, 7) == 0)
							issue(CMD_PEEK, 8'($urandom), 11'd0, 1'b0, '0);
						else
							issue(CMD_INSERT, 8'($urandom),
								CNT_W'($urandom_range(0, 2047)), 1'b0, '0);
					end
				end
				[3:5]: begin
					// Cursor walk: moves within the bounds in either direction, with peeks.
					reps = $urandom_range(1, 12);
					repeat (reps) begin
						if ($urandom_range(0, 4) == 0)
							issue(CMD_PEEK, 8'h00, 11'd0, 1'b0, '0);
						else if (gap_last == CAP
								|| (gap_first != 0 && $urandom_range(0, 1) == 0))
							issue(CMD_BACKWARD, 8'h00, pick_span(gap_first), 1'b0, '0);
						else
							issue(CMD_FORWARD, 8'h00, pick_span(CAP - gap_last), 1'b0, '0);
					end
				end
				[6:7]: begin
					// Local edits around the cursor.
					reps = $urandom_range(1, 8);
					repeat (reps) begin
						case ($urandom_range(0, 2))
							0: issue(CMD_DELETE, 8'($urandom), pick_span(CAP - gap_last),
								1'b0, '0);
							1: issue(CMD_PEEK, 8'($urandom), 11'd0, 1'b0, '0);
							default: issue(CMD_INSERT, 8'($urandom), 11'd0, 1'b0, '0);
						endcase
					end
				end
				8: begin
					// Noise: any code, any count, including out of range.
					reps = $urandom_range(1, 6);
					repeat (reps) begin
						op = CMD_W'($urandom_range(0, 7));
						if ($urandom_range(0, 1) == 0)
							issue(op, 8'($urandom), CNT_W'($urandom_range(0, 2047)), 1'b0, '0);
						else
							issue(op, 8'($urandom), CNT_W'($urandom_range(0, 20)), 1'b0, '0);
					end
				end
				default: begin
					issue(CMD_CLEAR, 8'($urandom), CNT_W'($urandom_range(0, 2047)), 1'b0, '0);
				end
			endcase
		end

		// Drop start only once busy is high after the last transfer.
		@(posedge clk);
		start <= 1'b0;
		while (pending_q.size() != 0)
			@(posedge clk);
		repeat (12)
			@(posedge clk);
		if (n_bad == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
